// File: design/sbm_pkg.sv
// Shared types and codes for the serial-loaded bank mapper.
package sbm_pkg;

   typedef struct packed {
      logic [15:0] address;
      logic [7:0]  data;
      logic        double_write;
   } sbm_req_type;

   typedef struct packed {
      logic [4:0] prg_bank_low;
      logic [4:0] prg_bank_high;
      logic [4:0] chr_bank_low;
      logic [4:0] chr_bank_high;
      logic [1:0] mirroring;
      logic       prg_ram_enabled;
      logic [1:0] prg_ram_bank;
   } sbm_rsp_type;

   typedef struct packed {
      logic [2:0] board_variant;
      logic [4:0] prg_last_bank;
      logic [4:0] chr_last_bank;
      logic       chr_is_ram;
   } sbm_cfg_type;

   typedef struct packed {
      logic [4:0] shift_value;
      logic [2:0] shift_count;
      logic [4:0] control_word;
      logic [4:0] chr_select_zero;
      logic [4:0] chr_select_one;
      logic [4:0] prg_select;
      logic       just_reset;
      logic       prg_upper_half;
      logic [4:0] prg_low;
      logic [4:0] prg_high;
      logic [4:0] chr_low;
      logic [4:0] chr_high;
      logic       ram_enabled;
      logic [1:0] ram_bank;
   } sbm_state_type;

   typedef enum logic [2:0] {
      VARIANT_PLAIN = 3'd0,
      VARIANT_SNROM = 3'd1,
      VARIANT_SOROM = 3'd2,
      VARIANT_SUROM = 3'd3,
      VARIANT_SXROM = 3'd4
   } sbm_variant_type;

   typedef enum logic [1:0] {
      CSR_BOARD_VARIANT = 2'd0,
      CSR_PRG_LAST_BANK = 2'd1,
      CSR_CHR_LAST_BANK = 2'd2,
      CSR_CHR_IS_RAM    = 2'd3
   } sbm_csr_index_type;

   typedef enum logic [1:0] {
      TARGET_CONTROL = 2'd0,
      TARGET_CHR0    = 2'd1,
      TARGET_CHR1    = 2'd2,
      TARGET_PRG     = 2'd3
   } sbm_target_type;

   localparam logic [4:0] CONTROL_RESET   = 5'h0C;
   localparam logic [4:0] PRG_MODE_FORCE  = 5'h0C;
   localparam logic [4:0] MASK_PRG_32K    = 5'h0E;
   localparam logic [4:0] MASK_PRG_16K    = 5'h0F;
   localparam logic [4:0] MASK_CHR_8K     = 5'h1E;
   localparam logic [4:0] MASK_FULL       = 5'h1F;
   localparam logic [2:0] SHIFT_LAST      = 3'd4;

   localparam sbm_state_type STATE_RESET = '{
      shift_value:     5'd0,
      shift_count:     3'd0,
      control_word:    CONTROL_RESET,
      chr_select_zero: 5'd0,
      chr_select_one:  5'd1,
      prg_select:      5'd0,
      just_reset:      1'b0,
      prg_upper_half:  1'b0,
      prg_low:         5'd0,
      prg_high:        5'd0,
      chr_low:         5'd0,
      chr_high:        5'd0,
      ram_enabled:     1'b1,
      ram_bank:        2'd0
   };

   localparam sbm_cfg_type CFG_RESET = '{
      board_variant: VARIANT_PLAIN,
      prg_last_bank: 5'd15,
      chr_last_bank: 5'd31,
      chr_is_ram:    1'b0
   };

endpackage

// File: design/sbm_next.sv
// Next-state and bank-output logic for one CPU write.
module sbm_next
   import sbm_pkg::*;
(
   input  sbm_state_type cur_state,
   input  sbm_cfg_type   cfg,
   input  sbm_req_type   req,
   output sbm_state_type next_state
);

   function automatic logic [4:0] limit_bank(input logic [4:0] v, input logic [4:0] last,
                                             input logic [4:0] mask);
      logic [4:0] r;
      r = (v > last) ? (v & last) : v;
      return r & mask;
   endfunction

   // board side effects of a CHR register; returns the CHR bank bits
   function automatic sbm_state_type apply_chr(input sbm_state_type s, input logic [4:0] reg_v,
                                              input logic [2:0] variant,
                                              output logic [4:0] bank);
      sbm_state_type r;
      r    = s;
      bank = {4'd0, reg_v[0]};
      case (variant)
         VARIANT_SNROM: begin
            r.ram_enabled = ~reg_v[4];
         end
         VARIANT_SOROM: begin
            r.ram_bank       = {1'b0, reg_v[3]};
            r.prg_upper_half = reg_v[4];
         end
         VARIANT_SUROM: begin
            r.prg_upper_half = reg_v[4];
         end
         VARIANT_SXROM: begin
            r.ram_bank       = reg_v[3:2];
            r.prg_upper_half = reg_v[4];
         end
         default: begin
            bank = reg_v;
         end
      endcase
      return r;
   endfunction

   function automatic sbm_state_type update_chr0(input sbm_state_type s, input sbm_cfg_type c);
      sbm_state_type r;
      logic [4:0]    bank;
      logic [4:0]    v;
      r = apply_chr(s, s.chr_select_zero, c.board_variant, bank);
      if (r.control_word[4]) begin
         r.chr_low = limit_bank(bank, c.chr_last_bank, MASK_FULL);
      end else if (!c.chr_is_ram) begin
         v          = limit_bank(bank, c.chr_last_bank, MASK_CHR_8K);
         r.chr_low  = v;
         r.chr_high = v | 5'd1;
      end
      return r;
   endfunction

   function automatic sbm_state_type update_chr1(input sbm_state_type s, input sbm_cfg_type c);
      sbm_state_type r;
      logic [4:0]    bank;
      r    = s;
      bank = 5'd0;
      if (s.control_word[4]) begin
         r          = apply_chr(s, s.chr_select_one, c.board_variant, bank);
         r.chr_high = limit_bank(bank, c.chr_last_bank, MASK_FULL);
      end
      return r;
   endfunction

   function automatic sbm_state_type update_prg(input sbm_state_type s, input sbm_cfg_type c);
      sbm_state_type r;
      logic [4:0]    up;
      logic [4:0]    v;
      r  = s;
      up = {s.prg_upper_half, 4'd0};
      case (s.control_word[3:2])
         2'd0, 2'd1: begin
            v          = up | limit_bank(s.prg_select, c.prg_last_bank, MASK_PRG_32K);
            r.prg_low  = v;
            r.prg_high = v + 5'd1;
         end
         2'd2: begin
            r.prg_low  = up;
            r.prg_high = up | limit_bank(s.prg_select, c.prg_last_bank, MASK_PRG_16K);
         end
         default: begin
            r.prg_low  = up | limit_bank(s.prg_select, c.prg_last_bank, MASK_PRG_16K);
            r.prg_high = up | {1'b0, c.prg_last_bank[3:0]};
         end
      endcase
      return r;
   endfunction

   sbm_state_type s;
   logic          skip;
   logic [4:0]    shifted;

   always_comb begin
      s       = cur_state;
      skip    = 1'b0;
      shifted = 5'd0;
      if (s.just_reset) begin
         s.just_reset = 1'b0;
         skip         = req.double_write;
      end
      if (!skip) begin
         if (req.data[7]) begin
            s.just_reset   = 1'b1;
            s.shift_value  = 5'd0;
            s.shift_count  = 3'd0;
            s.control_word = s.control_word | PRG_MODE_FORCE;
            s              = update_chr0(s, cfg);
            s              = update_chr1(s, cfg);
            s.prg_high     = {s.prg_upper_half, cfg.prg_last_bank[3:0]};
         end else begin
            shifted       = s.shift_value | ({4'd0, req.data[0]} << s.shift_count);
            s.shift_value = shifted;
            if (s.shift_count >= SHIFT_LAST) begin
               case (req.address[14:13])
                  TARGET_CONTROL: begin
                     s.control_word = shifted;
                     s              = update_chr0(s, cfg);
                     s              = update_chr1(s, cfg);
                  end
                  TARGET_CHR0: begin
                     s.chr_select_zero = shifted;
                     s                 = update_chr0(s, cfg);
                  end
                  TARGET_CHR1: begin
                     s.chr_select_one = shifted;
                     s                = update_chr1(s, cfg);
                  end
                  default: begin
                     s.prg_select  = shifted;
                     s.ram_enabled = ~shifted[4];
                  end
               endcase
               s             = update_prg(s, cfg);
               s.shift_value = 5'd0;
               s.shift_count = 3'd0;
            end else begin
               s.shift_count = s.shift_count + 3'd1;
            end
         end
      end
      next_state = s;
   end

endmodule

// File: design/serial_loaded_bank_mapper.sv
// Serial-loaded bank mapper: takes one cartridge write per cycle and returns the
// resulting PRG/CHR bank map in the next cycle. The only loop is the mapper state
// register, updated in one pass per request, so a request is accepted every cycle
// while the response register is empty or being taken. Configuration writes are
// always ready and take effect on the next request.
module serial_loaded_bank_mapper
   import sbm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  sbm_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output sbm_rsp_type rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);

   sbm_cfg_type   cfg_ff, cfg_in;
   sbm_state_type state_ff, state_in;
   sbm_state_type next_state;
   sbm_rsp_type   rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          req_accept;

   sbm_next u_next (
      .cur_state  (state_ff),
      .cfg        (cfg_ff),
      .req        (req_data),
      .next_state (next_state)
   );

   assign req_ready  = ~rsp_valid_ff | rsp_ready;
   assign req_accept = req_valid & req_ready;
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_BOARD_VARIANT: cfg_in.board_variant = csr_data[2:0];
            CSR_PRG_LAST_BANK: cfg_in.prg_last_bank = csr_data[4:0];
            CSR_CHR_LAST_BANK: cfg_in.chr_last_bank = csr_data[4:0];
            CSR_CHR_IS_RAM:    cfg_in.chr_is_ram    = csr_data[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      state_in     = req_accept ? next_state : state_ff;
      rsp_valid_in = req_accept | (rsp_valid_ff & ~rsp_ready);
      rsp_in       = rsp_ff;
      if (req_accept) begin
         rsp_in.prg_bank_low    = next_state.prg_low;
         rsp_in.prg_bank_high   = next_state.prg_high;
         rsp_in.chr_bank_low    = next_state.chr_low;
         rsp_in.chr_bank_high   = next_state.chr_high;
         rsp_in.mirroring       = next_state.control_word[1:0];
         rsp_in.prg_ram_enabled = next_state.ram_enabled;
         rsp_in.prg_ram_bank    = next_state.ram_bank;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= CFG_RESET;
         state_ff     <= STATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

// File: design/sbm_checker.sv
// Port-level checks for the serial-loaded bank mapper.
module sbm_checker
   import sbm_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input sbm_rsp_type rsp_data,
   input logic        csr_valid,
   input logic        csr_ready
);

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // every accepted request yields a response next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted request without response");

   // empty output stage never blocks requests
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request blocked with empty output");

   // no request taken while a response is held back
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request accepted over a stalled response");

   // register writes never wait
   assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("register write held off");

endmodule

bind serial_loaded_bank_mapper sbm_checker u_sbm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data),
   .csr_valid (csr_valid),
   .csr_ready (csr_ready)
);

// File: tb/sv/tb_top.sv
// Self-checking testbench for the serial-loaded bank mapper: random CPU writes, bank map check.
module tb_top;
   import sbm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int         RANDOM_PHASES     = 10;
   localparam int         WRITES_PER_PHASE  = 190;
   localparam int         LONG_HOLD_AT      = 300;
   localparam int         LONG_HOLD_CYCLES  = 120;
   localparam int         STUCK_LIMIT       = 1000;
   localparam logic [2:0] VARIANT_UNKNOWN   = 3'd7;
   localparam logic [1:0] PRG_MODE_FIX_LOW  = 2'd2;
   localparam logic [1:0] PRG_MODE_FIX_HIGH = 2'd3;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   sbm_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   sbm_rsp_type rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = 2'd0;
   logic [7:0]  csr_data  = 8'd0;

   serial_loaded_bank_mapper dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // mapper configuration as last written
   logic [2:0] cfg_variant;
   logic [4:0] cfg_prg_last;
   logic [4:0] cfg_chr_last;
   logic       cfg_chr_ram;

   // mapper state
   logic [4:0] shift_bits;
   logic [2:0] shift_len;
   logic [4:0] control_reg;
   logic [4:0] chr0_sel;
   logic [4:0] chr1_sel;
   logic [4:0] prg_sel;
   logic       after_reset;
   logic       upper_half;
   logic [4:0] prg_low;
   logic [4:0] prg_high;
   logic [4:0] chr_low;
   logic [4:0] chr_high;
   logic       ram_on;
   logic [1:0] ram_page;

   sbm_req_type pending_writes[$];
   sbm_rsp_type expected_maps[$];

   bit idle_on       = 1'b1;
   int send_gap      = 0;
   int sent_count    = 0;
   int checked_count = 0;
   int mismatches    = 0;
   int setting_count = 0;
   int stuck_cycles  = 0;

   function automatic logic [4:0] clamp_bank(input logic [4:0] v, input logic [4:0] last,
                                             input logic [4:0] mask);
      if (v > last)
         v = v & last;
      return v & mask;
   endfunction

   // board-specific side effects of a CHR register, returns the CHR bank bits
   function automatic logic [4:0] chr_bank_bits(input logic [4:0] r);
      case (cfg_variant)
         VARIANT_SNROM: begin
            ram_on = ~r[4];
            return {4'd0, r[0]};
         end
         VARIANT_SOROM: begin
            ram_page   = {1'b0, r[3]};
            upper_half = r[4];
            return {4'd0, r[0]};
         end
         VARIANT_SUROM: begin
            upper_half = r[4];
            return {4'd0, r[0]};
         end
         VARIANT_SXROM: begin
            ram_page   = r[3:2];
            upper_half = r[4];
            return {4'd0, r[0]};
         end
         default: return r;
      endcase
   endfunction

   function automatic void refresh_chr0();
      logic [4:0] v;
      v = chr_bank_bits(chr0_sel);
      if (control_reg[4]) begin
         chr_low = clamp_bank(v, cfg_chr_last, MASK_FULL);
      end else if (!cfg_chr_ram) begin
         v        = clamp_bank(v, cfg_chr_last, MASK_CHR_8K);
         chr_low  = v;
         chr_high = v | 5'd1;
      end
   endfunction

   function automatic void refresh_chr1();
      logic [4:0] v;
      if (control_reg[4]) begin
         v        = chr_bank_bits(chr1_sel);
         chr_high = clamp_bank(v, cfg_chr_last, MASK_FULL);
      end
   endfunction

   function automatic void refresh_prg();
      logic [4:0] up;
      logic [4:0] v;
      up = {upper_half, 4'd0};
      case (control_reg[3:2])
         PRG_MODE_FIX_LOW: begin
            v        = clamp_bank(prg_sel, cfg_prg_last, MASK_PRG_16K);
            prg_low  = up;
            prg_high = up | v;
         end
         PRG_MODE_FIX_HIGH: begin
            v        = clamp_bank(prg_sel, cfg_prg_last, MASK_PRG_16K);
            prg_low  = up | v;
            prg_high = up | (cfg_prg_last & MASK_PRG_16K);
         end
         default: begin
            v        = up | clamp_bank(prg_sel, cfg_prg_last, MASK_PRG_32K);
            prg_low  = v;
            prg_high = v + 5'd1;
         end
      endcase
   endfunction

   // applies one CPU write and returns the bank map that follows it
   function automatic sbm_rsp_type map_write(input sbm_req_type w);
      sbm_rsp_type m;
      bit          skip;
      skip = 1'b0;
      if (after_reset) begin
         after_reset = 1'b0;
         skip        = w.double_write;
      end
      if (!skip) begin
         if (w.data[7]) begin
            after_reset = 1'b1;
            shift_bits  = 5'd0;
            shift_len   = 3'd0;
            control_reg = control_reg | PRG_MODE_FORCE;
            refresh_chr0();
            refresh_chr1();
            prg_high = {upper_half, 4'd0} | (cfg_prg_last & MASK_PRG_16K);
         end else begin
            shift_bits = shift_bits | (5'(w.data[0]) << shift_len);
            if (shift_len >= SHIFT_LAST) begin
               case (sbm_target_type'(w.address[14:13]))
                  TARGET_CONTROL: begin
                     control_reg = shift_bits;
                     refresh_chr0();
                     refresh_chr1();
                  end
                  TARGET_CHR0: begin
                     chr0_sel = shift_bits;
                     refresh_chr0();
                  end
                  TARGET_CHR1: begin
                     chr1_sel = shift_bits;
                     refresh_chr1();
                  end
                  default: begin
                     prg_sel = shift_bits;
                     ram_on  = ~prg_sel[4];
                  end
               endcase
               refresh_prg();
               shift_bits = 5'd0;
               shift_len  = 3'd0;
            end else begin
               shift_len = shift_len + 3'd1;
            end
         end
      end
      m.prg_bank_low    = prg_low;
      m.prg_bank_high   = prg_high;
      m.chr_bank_low    = chr_low;
      m.chr_bank_high   = chr_high;
      m.mirroring       = control_reg[1:0];
      m.prg_ram_enabled = ram_on;
      m.prg_ram_bank    = ram_page;
      return m;
   endfunction

   function automatic void check_field(input string name, input logic [4:0] want,
                                       input logic [4:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endfunction

   function automatic logic [15:0] random_address();
      return 16'h8000 | 16'($urandom_range(0, 16'h7FFF));
   endfunction

   task automatic queue_write(input logic [15:0] a, input logic [7:0] d, input logic dbl);
      sbm_req_type w;
      w.address      = a;
      w.data         = d;
      w.double_write = dbl;
      pending_writes.push_back(w);
   endtask

   // five serial writes, low bit first; only the last address picks the register
   task automatic queue_load(input sbm_target_type t, input logic [4:0] v, input bit allow_dbl);
      logic [15:0] a;
      logic [7:0]  d;
      for (int i = 0; i < 5; i++) begin
         a = random_address();
         if (i == 4)
            a[14:13] = t;
         d = {1'b0, 6'($urandom), v[i]};
         queue_write(a, d, allow_dbl && ($urandom_range(0, 7) == 0));
      end
   endtask

   task automatic apply_setting(input logic [2:0] variant, input logic [4:0] prg_last,
                                input logic [4:0] chr_last, input logic chr_ram);
      sbm_csr_index_type order[4];
      logic [7:0]        value[4];
      order = '{CSR_BOARD_VARIANT, CSR_PRG_LAST_BANK, CSR_CHR_LAST_BANK, CSR_CHR_IS_RAM};
      value = '{8'(variant), 8'(prg_last), 8'(chr_last), 8'(chr_ram)};
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= order[i];
         csr_data  <= value[i];
         do @(posedge clock); while (!csr_ready);
         case (order[i])
            CSR_BOARD_VARIANT: cfg_variant  = value[i][2:0];
            CSR_PRG_LAST_BANK: cfg_prg_last = value[i][4:0];
            CSR_CHR_LAST_BANK: cfg_chr_last = value[i][4:0];
            default:           cfg_chr_ram  = value[i][0];
         endcase
      end
      csr_valid <= 1'b0;
      setting_count++;
   endtask

   task automatic drain();
      do @(posedge clock);
      while (pending_writes.size() != 0 || req_valid || expected_maps.size() != 0);
      repeat (2) @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_maps.push_back(map_write(req_data));
            sent_count++;
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_writes.size() != 0) begin
               req_data  <= pending_writes.pop_front();
               req_valid <= 1'b1;
               if (idle_on && $urandom_range(0, 5) == 0)
                  send_gap = $urandom_range(1, 18);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response receiver, with one long hold-off to back the block up
   always @(posedge clock) begin : receiver
      int  stall_left;
      int  rsp_taken;
      bit  long_hold_done;
      if (reset) begin
         stall_left     = 0;
         rsp_taken      = 0;
         long_hold_done = 1'b0;
         rsp_ready     <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            rsp_taken++;
         if (!long_hold_done && rsp_taken >= LONG_HOLD_AT) begin
            long_hold_done = 1'b1;
            stall_left     = LONG_HOLD_CYCLES;
         end else if (stall_left == 0 && idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 18);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // response monitor
   always @(posedge clock) begin : monitor
      sbm_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         checked_count++;
         if (expected_maps.size() == 0) begin
            $error("response with no request outstanding");
            mismatches++;
         end else begin
            want = expected_maps.pop_front();
            check_field("prg_bank_low", want.prg_bank_low, rsp_data.prg_bank_low);
            check_field("prg_bank_high", want.prg_bank_high, rsp_data.prg_bank_high);
            check_field("chr_bank_low", want.chr_bank_low, rsp_data.chr_bank_low);
            check_field("chr_bank_high", want.chr_bank_high, rsp_data.chr_bank_high);
            check_field("mirroring", 5'(want.mirroring), 5'(rsp_data.mirroring));
            check_field("prg_ram_enabled", 5'(want.prg_ram_enabled),
                        5'(rsp_data.prg_ram_enabled));
            check_field("prg_ram_bank", 5'(want.prg_ram_bank), 5'(rsp_data.prg_ram_bank));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin : stimulus
      int         queued;
      int         pick;
      logic [7:0] d;
      logic [2:0] variant;
      logic [4:0] prg_last;
      logic [4:0] chr_last;
      logic       chr_ram;

      cfg_variant  = CFG_RESET.board_variant;
      cfg_prg_last = CFG_RESET.prg_last_bank;
      cfg_chr_last = CFG_RESET.chr_last_bank;
      cfg_chr_ram  = CFG_RESET.chr_is_ram;
      shift_bits   = STATE_RESET.shift_value;
      shift_len    = STATE_RESET.shift_count;
      control_reg  = STATE_RESET.control_word;
      chr0_sel     = STATE_RESET.chr_select_zero;
      chr1_sel     = STATE_RESET.chr_select_one;
      prg_sel      = STATE_RESET.prg_select;
      after_reset  = STATE_RESET.just_reset;
      upper_half   = STATE_RESET.prg_upper_half;
      prg_low      = STATE_RESET.prg_low;
      prg_high     = STATE_RESET.prg_high;
      chr_low      = STATE_RESET.chr_low;
      chr_high     = STATE_RESET.chr_high;
      ram_on       = STATE_RESET.ram_enabled;
      ram_page     = STATE_RESET.ram_bank;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset-time settings
      apply_setting(CFG_RESET.board_variant, CFG_RESET.prg_last_bank,
                    CFG_RESET.chr_last_bank, CFG_RESET.chr_is_ram);
      queue_write(16'h8000, 8'h00, 1'b1);         // double write with no reset before it
      queue_write(16'hFFFF, 8'hFF, 1'b0);         // reset write
      queue_write(16'h8000, 8'h01, 1'b1);         // ignored double write
      queue_load(TARGET_CONTROL, 5'h10, 1'b0);    // 4K CHR, 32K PRG
      queue_load(TARGET_CHR0, 5'h1F, 1'b0);
      queue_load(TARGET_CHR1, 5'h00, 1'b0);
      queue_load(TARGET_PRG, 5'h1F, 1'b0);        // RAM disabled
      queue_write(16'hE000, 8'h80, 1'b0);
      queue_write(16'h8000, 8'h7F, 1'b0);         // plain write after reset is taken
      drain();

      for (int p = 1; p <= RANDOM_PHASES; p++) begin
         case (p)
            1: begin variant = VARIANT_PLAIN; prg_last = 5'd31; chr_last = 5'd31; chr_ram = '0; end
            2: begin variant = VARIANT_SNROM; prg_last = 5'd0;  chr_last = 5'd0;  chr_ram = '1; end
            3: begin variant = VARIANT_SOROM; prg_last = 5'd31; chr_last = 5'd15; chr_ram = '0; end
            4: begin variant = VARIANT_SUROM; prg_last = 5'd15; chr_last = 5'd31; chr_ram = '1; end
            5: begin variant = VARIANT_SXROM; prg_last = 5'd31; chr_last = 5'd31; chr_ram = '0; end
            6: begin
               variant  = VARIANT_UNKNOWN;
               prg_last = 5'($urandom);
               chr_last = 5'($urandom);
               chr_ram  = 1'b0;
            end
            default: begin
               variant  = 3'($urandom);
               prg_last = 5'($urandom);
               chr_last = 5'($urandom);
               chr_ram  = 1'($urandom);
            end
         endcase
         apply_setting(variant, prg_last, chr_last, chr_ram);
         idle_on <= (p != 4) && (p != RANDOM_PHASES);

         queued = 0;
         while (queued < WRITES_PER_PHASE) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
               queue_load(sbm_target_type'($urandom_range(0, 3)), 5'($urandom), 1'b1);
               queued += 5;
            end else if (pick < 8) begin
               queue_write(random_address(), 8'h80 | 8'($urandom_range(0, 127)), 1'($urandom));
               queued++;
               if ($urandom_range(0, 1) == 1) begin
                  queue_write(random_address(), 8'($urandom), 1'b1);
                  queued++;
               end
            end else begin
               d = 8'($urandom);
               if ($urandom_range(0, 3) != 0)
                  d[7] = 1'b0;
               queue_write(random_address(), d, 1'($urandom));
               queued++;
            end
         end
         drain();
      end

      repeat (4) @(posedge clock);
      if (expected_maps.size() != 0) begin
         $error("%0d expected responses never arrived", expected_maps.size());
         mismatches++;
      end
      $display("Ran %0d CPU writes under %0d mapper settings", sent_count, setting_count);
      $display("(all board variants, bank limits 0..31)");
      $display("Checked %0d bank map responses, %0d mismatches", checked_count, mismatches);
      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
